FILE: rtl/dpo_pkg.sv
// Package: payload types, calendar tables and constants for the period overlap counter.
`default_nettype none
package dpo_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DAYS_W   = 22;
  localparam int SERIAL_W = 23;
  localparam int LANES    = 4;

  // Year offset that keeps the leap pattern and avoids year 0 handling.
  localparam int YEAR_SHIFT = 400;
  // floor(x / 25) == (x * RECIP_25) >> RECIP_SHIFT for x below 4681.
  localparam int RECIP_25    = 2622;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = 24;

  localparam logic [DAYS_W-1:0] OVL_MAX = {DAYS_W{1'b1}};

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  start1_year;
    logic [MONTH_W-1:0] start1_month;
    logic [DAY_W-1:0]   start1_day;
    logic [YEAR_W-1:0]  end1_year;
    logic [MONTH_W-1:0] end1_month;
    logic [DAY_W-1:0]   end1_day;
    logic [YEAR_W-1:0]  start2_year;
    logic [MONTH_W-1:0] start2_month;
    logic [DAY_W-1:0]   start2_day;
    logic [YEAR_W-1:0]  end2_year;
    logic [MONTH_W-1:0] end2_month;
    logic [DAY_W-1:0]   end2_day;
  } req_t;

  typedef struct packed {
    logic [DAYS_W-1:0] overlap_days;
    logic              date_error;
  } rsp_t;

  // Length of a month; months outside 1..12 give 0.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dpo_stream_if.sv
// Interface: valid/ready channel carrying one payload item.
`default_nettype none
interface dpo_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/date_period_overlap_days.sv
// Top level: pipelined day count of the overlap of two Gregorian date periods.
//
// Channels: req (sink) takes one item holding two periods, each a start and
// an end date (year, month, day). rsp (source) returns one item per request:
// overlap_days, the days from the later start to the earlier end with the end
// day excluded (0 when the periods do not overlap, saturated at 22 bits), and
// date_error, set when any month or day is out of range (count then 0).
// Both use valid/ready; an item moves when valid and ready are high together.
// Pipeline: four register stages (year products, serial day numbers, max/min of
// the bounds, clamped difference); an accepted item passes through them in that
// order, and rsp.valid rises when it reaches the last stage.
// Throughput: one item per cycle; each stage is taken when it is empty or its
// successor moves, so the pipeline stays full while the receiver is ready.
// Stall: when rsp.ready is low the result holds and the stages behind it fill;
// req.ready drops once all four stages hold an item. Nothing is lost or doubled.
// Reset (rst, synchronous, active high) empties all stages; payload registers
// are not cleared.
`default_nettype none
module date_period_overlap_days (
  input  wire logic      clk,
  input  wire logic      rst,
  dpo_stream_if.sink     req,
  dpo_stream_if.source   rsp
);

  localparam int L = dpo_pkg::LANES;

  // lane 0: start1, 1: end1, 2: start2, 3: end2
  logic [dpo_pkg::YEAR_W-1:0]  lane_y [L];
  logic [dpo_pkg::MONTH_W-1:0] lane_m [L];
  logic [dpo_pkg::DAY_W-1:0]   lane_d [L];
  dpo_pkg::req_t               req_data;

  logic adv1, adv2, adv3, adv4;
  logic v1, v2, v3, v4;

  // stage 1 registers
  logic [dpo_pkg::SERIAL_W-1:0] yy365  [L];
  logic [12:0]                  q      [L];
  logic [dpo_pkg::PROD_W-1:0]   prod_p [L];
  logic [11:0]                  qy     [L];
  logic [dpo_pkg::PROD_W-1:0]   prod_y [L];
  logic [1:0]                   ylow   [L];
  logic [dpo_pkg::MONTH_W-1:0]  m1     [L];
  logic [dpo_pkg::DAY_W-1:0]    d1     [L];

  // stage 2 registers
  logic [dpo_pkg::SERIAL_W-1:0] serial [L];
  logic [L-1:0]                 ok;

  // stage 3 registers
  logic [dpo_pkg::SERIAL_W-1:0] lo, hi;
  logic                         bad;

  // stage 4 registers
  logic [dpo_pkg::DAYS_W-1:0]   overlap_days;
  logic                         date_error;

  assign req_data = req.data;

  always_comb begin
    lane_y[0] = req_data.start1_year;
    lane_m[0] = req_data.start1_month;
    lane_d[0] = req_data.start1_day;
    lane_y[1] = req_data.end1_year;
    lane_m[1] = req_data.end1_month;
    lane_d[1] = req_data.end1_day;
    lane_y[2] = req_data.start2_year;
    lane_m[2] = req_data.start2_month;
    lane_d[2] = req_data.start2_day;
    lane_y[3] = req_data.end2_year;
    lane_m[3] = req_data.end2_month;
    lane_d[3] = req_data.end2_day;
  end

  // a stage loads when it is empty or its successor moves on
  assign adv4      = !v4 || rsp.ready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= req.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_lane
    logic [14:0] yy;
    logic [14:0] p;
    logic [7:0]  cent_p;
    logic [7:0]  cent_y;
    logic [11:0] cent_y25;
    logic        leap;
    logic        ok_next;
    logic [dpo_pkg::SERIAL_W-1:0] serial_next;

    assign yy = 15'(lane_y[i]) + 15'(dpo_pkg::YEAR_SHIFT);
    assign p  = yy - 15'd1;

    // stage 1: year products and reciprocal multiplies for the /25 steps
    always_ff @(posedge clk) begin
      if (adv1) begin
        yy365[i]  <= dpo_pkg::SERIAL_W'(yy) * dpo_pkg::SERIAL_W'(365);
        q[i]      <= p[14:2];
        prod_p[i] <= dpo_pkg::PROD_W'(p[14:2]) * dpo_pkg::PROD_W'(dpo_pkg::RECIP_25);
        qy[i]     <= lane_y[i][13:2];
        prod_y[i] <= dpo_pkg::PROD_W'(lane_y[i][13:2]) *
                     dpo_pkg::PROD_W'(dpo_pkg::RECIP_25);
        ylow[i]   <= lane_y[i][1:0];
        m1[i]     <= lane_m[i];
        d1[i]     <= lane_d[i];
      end
    end

    // stage 2: leap year, range check and serial day number
    assign cent_p   = prod_p[i][dpo_pkg::RECIP_SHIFT +: 8];
    assign cent_y   = prod_y[i][dpo_pkg::RECIP_SHIFT +: 8];
    assign cent_y25 = 12'(cent_y) * 12'd25;
    // divisible by 4, and either not by 100 or also by 400
    assign leap     = (ylow[i] == 2'd0) && ((qy[i] != cent_y25) || (cent_y[1:0] == 2'd0));
    assign ok_next  = (m1[i] >= dpo_pkg::MONTH_JAN) && (m1[i] <= dpo_pkg::MONTH_DEC) &&
                      (d1[i] != '0) && (d1[i] <= dpo_pkg::month_days(m1[i], leap));
    assign serial_next = yy365[i] + dpo_pkg::SERIAL_W'(q[i])
                       - dpo_pkg::SERIAL_W'(cent_p) + dpo_pkg::SERIAL_W'(cent_p[7:2])
                       + dpo_pkg::SERIAL_W'(dpo_pkg::days_before(m1[i]))
                       + dpo_pkg::SERIAL_W'(leap && (m1[i] > dpo_pkg::MONTH_FEB))
                       + dpo_pkg::SERIAL_W'(d1[i]);

    always_ff @(posedge clk) begin
      if (adv2) begin
        serial[i] <= serial_next;
        ok[i]     <= ok_next;
      end
    end
  end

  // stage 3: later start, earlier end
  always_ff @(posedge clk) begin
    if (adv3) begin
      lo  <= (serial[0] > serial[2]) ? serial[0] : serial[2];
      hi  <= (serial[1] < serial[3]) ? serial[1] : serial[3];
      bad <= !(&ok);
    end
  end

  // stage 4: clamp at zero, saturate, drop the count on a bad date
  logic [dpo_pkg::SERIAL_W-1:0] diff;
  logic [dpo_pkg::DAYS_W-1:0]   cnt_next;

  assign diff = hi - lo;

  always_comb begin
    if (bad || !(hi > lo)) begin
      cnt_next = '0;
    end else if (diff[dpo_pkg::SERIAL_W-1]) begin
      cnt_next = dpo_pkg::OVL_MAX;
    end else begin
      cnt_next = diff[dpo_pkg::DAYS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      overlap_days <= cnt_next;
      date_error   <= bad;
    end
  end

  assign rsp.valid             = v4;
  assign rsp.data.overlap_days = overlap_days;
  assign rsp.data.date_error   = date_error;

`ifndef SYNTH
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.date_error |-> rsp.data.overlap_days == '0)
    else $error("count not zero on a date error");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed while stalled");

  a_free_ready: assert property (@(posedge clk) disable iff (rst)
    (!v4 || rsp.ready) |-> req.ready)
    else $error("input held off while the output moves");

  a_accept_reaches_out: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && rsp.ready ##1 rsp.ready ##1 rsp.ready ##1 rsp.ready
    |=> rsp.valid)
    else $error("accepted item missing at the output");
`endif

endmodule
`default_nettype wire

FILE: tb/overlap_days_monitor.sv
// Monitor: predicts the overlap day count of each accepted query and checks every result.
module overlap_days_monitor
  import dpo_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_ready,
  input  req_t  req_data,
  input  logic  rsp_valid,
  input  logic  rsp_ready,
  input  rsp_t  rsp_data,
  output int    mismatches,
  output int    pending,
  output int    n_checked,
  output int    n_flagged,
  output int    n_overlapping,
  output int    n_saturated
);

  rsp_t predicted_counts[$];

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      MONTH_FEB:             return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Serial day number; shift the year by 400 so year 0 keeps the leap pattern.
  function automatic longint unsigned day_number(int unsigned y, int unsigned m,
                                                 int unsigned d);
    longint unsigned yy, p, s;
    yy = y + 400;
    p = yy - 1;
    s = yy * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) begin
      s += month_length(y, k);
    end
    return s + d;
  endfunction

  function automatic rsp_t overlap_of_periods(req_t q);
    int unsigned     y[4], m[4], d[4];
    longint unsigned sn[4], lo, hi, cnt;
    rsp_t            r;
    y = '{q.start1_year, q.end1_year, q.start2_year, q.end2_year};
    m = '{q.start1_month, q.end1_month, q.start2_month, q.end2_month};
    d = '{q.start1_day, q.end1_day, q.start2_day, q.end2_day};
    r = '0;
    for (int k = 0; k < 4; k++) begin
      if (d[k] < 1 || d[k] > month_length(y[k], m[k])) r.date_error = 1'b1;
    end
    if (!r.date_error) begin
      for (int k = 0; k < 4; k++) sn[k] = day_number(y[k], m[k], d[k]);
      lo = (sn[0] > sn[2]) ? sn[0] : sn[2];
      hi = (sn[1] < sn[3]) ? sn[1] : sn[3];
      cnt = (hi > lo) ? hi - lo : 0;
      if (cnt > OVL_MAX) cnt = OVL_MAX;
      r.overlap_days = cnt[DAYS_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    int   errs;
    if (rst) begin
      predicted_counts.delete();
      mismatches    <= 0;
      pending       <= 0;
      n_checked     <= 0;
      n_flagged     <= 0;
      n_overlapping <= 0;
      n_saturated   <= 0;
    end else begin
      errs = 0;
      // retire before predicting: a result never answers a query accepted on the same edge
      if (rsp_valid && rsp_ready) begin
        if (predicted_counts.size() == 0) begin
          $error("result with no query waiting: overlap_days %0d date_error %0b",
                 rsp_data.overlap_days, rsp_data.date_error);
          errs++;
        end else begin
          want = predicted_counts.pop_front();
          if (rsp_data.overlap_days !== want.overlap_days) begin
            $error("overlap_days: expected %0d, actual %0d",
                   want.overlap_days, rsp_data.overlap_days);
            errs++;
          end
          if (rsp_data.date_error !== want.date_error) begin
            $error("date_error: expected %0b, actual %0b",
                   want.date_error, rsp_data.date_error);
            errs++;
          end
          n_checked     <= n_checked + 1;
          n_flagged     <= n_flagged + want.date_error;
          n_overlapping <= n_overlapping + (want.overlap_days != 0);
          n_saturated   <= n_saturated + (want.overlap_days == OVL_MAX);
        end
      end
      if (req_valid && req_ready) predicted_counts.push_back(overlap_of_periods(req_data));
      mismatches <= mismatches + errs;
      pending    <= predicted_counts.size();
    end
  end

endmodule

FILE: tb/date_period_overlap_days_tb.sv
// Testbench top: drives date period queries into the overlap counter and gives the verdict.
module date_period_overlap_days_tb;
  import dpo_pkg::*;

  localparam int N_RANDOM     = 1700;
  localparam int N_CALM_TAIL  = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
  } cal_date_t;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches, pending, n_checked, n_flagged, n_overlapping, n_saturated;
  int   cycle_cnt;

  dpo_stream_if #(.T(req_t)) req ();
  dpo_stream_if #(.T(rsp_t)) rsp ();

  date_period_overlap_days i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  overlap_days_monitor i_monitor (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_data      (req.data),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_data      (rsp.data),
    .mismatches    (mismatches),
    .pending       (pending),
    .n_checked     (n_checked),
    .n_flagged     (n_flagged),
    .n_overlapping (n_overlapping),
    .n_saturated   (n_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall in bursts, with a stall rate that changes over the run and no stalls in the calm tail.
  int sink_hold;
  int sink_pct;
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp.ready <= 1'b1;
      sink_hold <= 0;
      sink_pct  <= 20;
    end else begin
      if (cycle_cnt % 128 == 0) sink_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      if (sink_hold != 0) begin
        sink_hold <= sink_hold - 1;
        if (sink_hold == 1) rsp.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < sink_pct) begin
        rsp.ready <= 1'b0;
        sink_hold <= $urandom_range(1, 8);
      end
    end
  end

  function automatic cal_date_t cal_date(int unsigned y, int unsigned m, int unsigned d);
    cal_date_t c;
    c.y = YEAR_W'(y);
    c.m = MONTH_W'(m);
    c.d = DAY_W'(d);
    return c;
  endfunction

  // Mostly valid dates; late days now and then, some of which fall past the month end.
  function automatic cal_date_t any_date(int unsigned y_lo, int unsigned y_hi);
    int unsigned d;
    d = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    return cal_date($urandom_range(y_lo, y_hi), $urandom_range(1, 12), d);
  endfunction

  function automatic req_t periods(cal_date_t s1, cal_date_t e1, cal_date_t s2, cal_date_t e2);
    req_t q;
    q.start1_year = s1.y;  q.start1_month = s1.m;  q.start1_day = s1.d;
    q.end1_year   = e1.y;  q.end1_month   = e1.m;  q.end1_day   = e1.d;
    q.start2_year = s2.y;  q.start2_month = s2.m;  q.start2_day = s2.d;
    q.end2_year   = e2.y;  q.end2_month   = e2.m;  q.end2_day   = e2.d;
    return q;
  endfunction

  function automatic req_t raw_query();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t random_query();
    int unsigned r, base, mo;
    int          offs[5];
    cal_date_t   dt[4];
    offs = '{0, 100, 300, 4, 1};
    r = $urandom_range(0, 99);
    if (r < 70) begin
      // four dates within a few years, so overlap, nesting and reversal all show up
      base = $urandom_range(0, 9999);
      for (int k = 0; k < 4; k++) dt[k] = any_date(base, base + 2);
      if (r >= 55) begin
        // shared bounds: touching periods, identical periods, an empty period
        case ($urandom_range(0, 3))
          0: dt[2] = dt[1];
          1: dt[3] = dt[0];
          2: begin
            dt[2] = dt[0];
            dt[3] = dt[1];
          end
          default: dt[0] = dt[1];
        endcase
      end
    end else if (r < 80) begin
      for (int k = 0; k < 4; k++) dt[k] = any_date(0, (1 << YEAR_W) - 1);
    end else if (r < 90) begin
      // end of February and start of March in century, quad-century, leap and common years
      base = $urandom_range(0, 39) * 400 + offs[$urandom_range(0, 4)];
      for (int k = 0; k < 4; k++) begin
        mo = $urandom_range(MONTH_FEB, MONTH_FEB + 1);
        dt[k] = cal_date(base + $urandom_range(0, 1), mo,
                         (mo == MONTH_FEB) ? $urandom_range(27, 29) : $urandom_range(1, 2));
      end
    end else begin
      return raw_query();
    end
    return periods(dt[0], dt[1], dt[2], dt[3]);
  endfunction

  task automatic send_query(input req_t q);
    req.data  <= q;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic idle_sender(input int n);
    req.valid <= 1'b0;
    req.data  <= raw_query();
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every outstanding result has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    req_t directed[$];
    int   src_pct;
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.data  <= '0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // inner period inside the outer one, partial overlap, touching, disjoint
    directed.push_back(periods(cal_date(2000, 1, 1), cal_date(2000, 12, 31),
                               cal_date(2000, 3, 1), cal_date(2000, 4, 1)));
    directed.push_back(periods(cal_date(2000, 3, 1), cal_date(2000, 4, 1),
                               cal_date(2000, 1, 1), cal_date(2000, 12, 31)));
    directed.push_back(periods(cal_date(2019, 6, 15), cal_date(2021, 2, 10),
                               cal_date(2020, 1, 1), cal_date(2023, 7, 4)));
    directed.push_back(periods(cal_date(2010, 1, 1), cal_date(2010, 5, 5),
                               cal_date(2010, 5, 5), cal_date(2010, 9, 9)));
    directed.push_back(periods(cal_date(2010, 1, 1), cal_date(2010, 5, 4),
                               cal_date(2011, 5, 5), cal_date(2012, 9, 9)));
    // reversed period, identical periods
    directed.push_back(periods(cal_date(2015, 8, 1), cal_date(2015, 2, 1),
                               cal_date(2015, 1, 1), cal_date(2015, 12, 1)));
    directed.push_back(periods(cal_date(1999, 12, 31), cal_date(2001, 1, 1),
                               cal_date(1999, 12, 31), cal_date(2001, 1, 1)));
    // whole calendar range, then beyond it into saturation
    directed.push_back(periods(cal_date(1, 1, 1), cal_date(9999, 12, 31),
                               cal_date(1, 1, 1), cal_date(9999, 12, 31)));
    directed.push_back(periods(cal_date(0, 1, 1), cal_date(16383, 12, 31),
                               cal_date(0, 1, 1), cal_date(16383, 12, 31)));
    // leap days: valid in 2000, 2004 and year 0, invalid in 1900 and 2001
    directed.push_back(periods(cal_date(2000, 2, 29), cal_date(2004, 2, 29),
                               cal_date(0, 2, 29), cal_date(2004, 3, 1)));
    directed.push_back(periods(cal_date(1900, 2, 29), cal_date(1901, 1, 1),
                               cal_date(1900, 1, 1), cal_date(1901, 1, 1)));
    directed.push_back(periods(cal_date(2001, 1, 1), cal_date(2002, 1, 1),
                               cal_date(2001, 1, 1), cal_date(2001, 2, 29)));
    // month and day out of range, then a valid query whose second period is empty
    directed.push_back(periods(cal_date(2020, 0, 1), cal_date(2021, 1, 1),
                               cal_date(2020, 1, 1), cal_date(2021, 1, 1)));
    directed.push_back(periods(cal_date(2020, 1, 1), cal_date(2021, 13, 1),
                               cal_date(2020, 1, 1), cal_date(2021, 1, 1)));
    directed.push_back(periods(cal_date(2020, 1, 1), cal_date(2021, 1, 1),
                               cal_date(2020, 15, 1), cal_date(2021, 1, 1)));
    directed.push_back(periods(cal_date(2020, 1, 1), cal_date(2021, 1, 1),
                               cal_date(2020, 1, 1), cal_date(2021, 1, 0)));
    directed.push_back(periods(cal_date(2020, 4, 31), cal_date(2021, 1, 31),
                               cal_date(2020, 1, 31), cal_date(2021, 1, 31)));
    directed.push_back(periods(cal_date(2020, 1, 31), cal_date(2021, 1, 31),
                               cal_date(2020, 12, 31), cal_date(2020, 12, 31)));

    foreach (directed[i]) send_query(directed[i]);
    wait_drained();

    src_pct = 20;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) src_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      if (i == N_RANDOM / 2) wait_drained();
      if (i == N_RANDOM - N_CALM_TAIL) calm = 1'b1;
      if (!calm && $urandom_range(0, 99) < src_pct) idle_sender($urandom_range(1, 8));
      send_query(random_query());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results over %0d directed and %0d random queries",
             n_checked, directed.size(), N_RANDOM);
    $display("%0d flagged bad dates, %0d nonzero overlaps, %0d saturated counts",
             n_flagged, n_overlapping, n_saturated);
    if (mismatches + pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dpo_pkg.sv
rtl/dpo_stream_if.sv
rtl/date_period_overlap_days.sv
tb/overlap_days_monitor.sv
tb/date_period_overlap_days_tb.sv
